>>> hdl/avtc_pkg.sv
// shared types, character codes and sgr colour helpers for the text console
// no dependencies; imported by the controller, datapath, top level and testbench
`default_nettype none

package avtc_pkg;

    // operation codes
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // character codes seen by the parser
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SGR      = 8'h6D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam int          CELL_W     = 16;
    localparam logic [7:0]  ATTR_RESET = 8'h0F;
    localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

    // ansi colour index to vga colour index
    localparam logic [2:0] ANSI_TO_VGA [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
        logic       bold;
    } sgr_t;

    localparam sgr_t SGR_DEFAULT = '{fg: 4'd7, bg: 4'd0, bold: 1'b0};

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic feed;
        logic rd_capture;
        logic scroll_issue;
        logic sweep_step;
        logic load_result;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scroll_need;
        logic sweep_last;
    } ctrl_sts_t;

    // apply one sgr parameter to the running colour state
    function automatic sgr_t sgr_apply(sgr_t s, logic [7:0] p);
        sgr_t r;
        r = s;
        if (p == 8'd0) begin
            r = SGR_DEFAULT;
        end
        else if (p == 8'd1) begin
            r.bold = 1'b1;
        end
        else if (p >= 8'd30 && p <= 8'd37) begin
            r.fg = {1'b0, ANSI_TO_VGA[3'(p - 8'd30)]};
        end
        else if (p >= 8'd40 && p <= 8'd47) begin
            r.bg = {1'b0, ANSI_TO_VGA[3'(p - 8'd40)]};
        end
        else if (p >= 8'd90 && p <= 8'd97) begin
            r.fg = {1'b1, ANSI_TO_VGA[3'(p - 8'd90)]};
        end
        else if (p >= 8'd100 && p <= 8'd107) begin
            r.bg = {1'b1, ANSI_TO_VGA[3'(p - 8'd100)]};
        end
        return r;
    endfunction

    // bold brightens a normal foreground
    function automatic logic [7:0] sgr_attr(sgr_t s);
        return {s.bg, s.fg[3] | s.bold, s.fg[2:0]};
    endfunction

endpackage

`default_nettype wire

>>> hdl/avtc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module avtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/avtc_ctrl.sv
// sequencing state machine of the text console: clear sweep, feed, read, scroll
// depends on avtc_pkg
`default_nettype none

module avtc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  operation,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output avtc_pkg::ctrl_cmd_t        cmd,
    input  wire avtc_pkg::ctrl_sts_t   sts
);

    import avtc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FEED,
        S_RD_ADDR,
        S_RD_DATA,
        S_SCROLL,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (operation == OP_READ) ? S_RD_ADDR : S_FEED;
                end
            end
            S_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = sts.scroll_need ? S_SCROLL : S_DONE;
            end
            S_RD_ADDR:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll_issue = 1'b1;
                cmd.sweep_step   = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/avtc_datapath.sv
// console datapath: csi parser, sgr state, cursor, screen ram and result registers
// depends on avtc_pkg and avtc_ram
`default_nettype none

module avtc_datapath #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_PARAMS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire avtc_pkg::ctrl_cmd_t  cmd,
    output avtc_pkg::ctrl_sts_t       sts,
    input  wire logic                 operation,
    input  wire logic [7:0]           data_byte,
    input  wire logic [10:0]          read_address,
    output logic      [10:0]          cursor_position,
    output logic                      cursor_updated,
    output logic      [7:0]           colour_attribute,
    output logic      [15:0]          cell_data
);

    import avtc_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int CNTW  = $clog2(MAX_PARAMS + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    // control state
    logic [1:0]      phase_reg, phase_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [7:0]      acc_reg, acc_next;
    logic            has_reg, has_next;
    sgr_t            sgr_reg, sgr_next;
    logic [7:0]      attr_reg, attr_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    logic            pipe_valid_reg, pipe_valid_next;

    // payload
    logic            op_reg;
    logic [7:0]      byte_reg;
    logic [10:0]     addr_reg;
    logic [AW-1:0]   pipe_addr_reg;
    logic            pipe_blank_reg;
    logic [15:0]     cell_reg, cell_next;
    logic            upd_reg, upd_next;
    logic [10:0]     out_cursor_reg;
    logic            out_upd_reg;
    logic [7:0]      out_attr_reg;
    logic [15:0]     out_cell_reg;

    // ram ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    // status to the controller
    logic            scroll_need;
    logic            sweep_last;

    // parser helpers
    logic            is_digit;
    logic [11:0]     acc_wide;
    logic [7:0]      acc_sat;
    logic [7:0]      push_val;
    logic            do_push;
    logic            can_push;
    sgr_t            sgr_pushed;
    logic [CW-1:0]   cand;
    logic [15:0]     blank_cell;

    assign blank_cell = {attr_reg, CH_SPACE};
    assign is_digit   = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign acc_wide   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {8'd0, 4'(byte_reg - CH_ZERO)};
    assign acc_sat    = !has_reg ? 8'(byte_reg - CH_ZERO)
                      : (acc_wide > 12'd255) ? 8'd255 : acc_wide[7:0];
    assign push_val   = has_reg ? acc_reg : 8'd0;
    assign do_push    = (byte_reg == CH_SEMI) || has_reg;
    assign can_push   = count_reg < CNTW'(MAX_PARAMS);
    assign sgr_pushed = sgr_apply(sgr_reg, push_val);

    assign ram_raddr  = cmd.scroll_issue ? AW'(sweep_reg + AW'(COLUMNS)) : AW'(addr_reg);
    assign sweep_last = (sweep_reg == AW'(CELLS - 1));
    assign sts        = '{scroll_need: scroll_need, sweep_last: sweep_last};

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        has_next        = has_reg;
        sgr_next        = sgr_reg;
        attr_next       = attr_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        cell_next       = cell_reg;
        upd_next        = upd_reg;
        cand            = cursor_reg;
        scroll_need     = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;

        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = CELL_RESET;
        end
        else if (pipe_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pipe_addr_reg;
            ram_wdata = pipe_blank_reg ? blank_cell : ram_rdata;
        end

        if (cmd.rd_capture)
        begin
            cell_next = (32'(addr_reg) < CELLS) ? ram_rdata : 16'd0;
            upd_next  = 1'b0;
        end

        if (cmd.feed)
        begin
            cell_next = 16'd0;
            upd_next  = 1'b0;
            if (phase_reg == PH_ESC && byte_reg == CH_LBRACKET)
            begin
                phase_next = PH_CSI;
                count_next = '0;
                acc_next   = 8'd0;
                has_next   = 1'b0;
                sgr_next   = SGR_DEFAULT;
            end
            else if (phase_reg == PH_CSI)
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                    has_next = 1'b1;
                end
                else
                begin
                    if (do_push && can_push)
                    begin
                        count_next = count_reg + 1'b1;
                        sgr_next   = sgr_pushed;
                    end
                    if (byte_reg != CH_SEMI)
                    begin
                        phase_next = PH_IDLE;
                        if (byte_reg == CH_SGR)
                        begin
                            attr_next = sgr_attr((do_push && can_push) ? sgr_pushed : sgr_reg);
                        end
                    end
                    acc_next = 8'd0;
                    has_next = 1'b0;
                end
            end
            else
            begin
                // idle byte, or a byte after escape that does not open csi
                phase_next = PH_IDLE;
                if (byte_reg == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else if (!byte_reg[7])
                begin
                    upd_next = 1'b1;
                    if (byte_reg == CH_LF)
                    begin
                        cand     = cursor_reg - CW'(col_reg) + CW'(COLUMNS);
                        col_next = '0;
                    end
                    else if (byte_reg == CH_CR)
                    begin
                        cand     = cursor_reg - CW'(col_reg);
                        col_next = '0;
                    end
                    else if (byte_reg == CH_BS)
                    begin
                        if (cursor_reg != '0)
                        begin
                            cand      = cursor_reg - 1'b1;
                            col_next  = (col_reg == '0) ? COLW'(COLUMNS - 1) : col_reg - 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = AW'(cursor_reg - 1'b1);
                            ram_wdata = blank_cell;
                        end
                    end
                    else
                    begin
                        cand      = cursor_reg + 1'b1;
                        col_next  = (col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = AW'(cursor_reg);
                        ram_wdata = {attr_reg, byte_reg};
                    end
                    scroll_need = (cand >= CW'(CELLS));
                    cursor_next = scroll_need ? cand - CW'(COLUMNS) : cand;
                end
            end
        end
    end

    always_comb
    begin
        sweep_next      = sweep_reg;
        pipe_valid_next = cmd.scroll_issue;
        if (cmd.sweep_step)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            count_reg      <= '0;
            acc_reg        <= 8'd0;
            has_reg        <= 1'b0;
            sgr_reg        <= SGR_DEFAULT;
            attr_reg       <= ATTR_RESET;
            cursor_reg     <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            acc_reg        <= acc_next;
            has_reg        <= has_next;
            sgr_reg        <= sgr_next;
            attr_reg       <= attr_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            byte_reg <= data_byte;
            addr_reg <= read_address;
        end
        if (cmd.scroll_issue)
        begin
            pipe_addr_reg  <= sweep_reg;
            pipe_blank_reg <= (sweep_reg >= AW'(CELLS - COLUMNS));
        end
        cell_reg <= cell_next;
        upd_reg  <= upd_next;
        if (cmd.load_result)
        begin
            out_cursor_reg <= 11'(cursor_reg);
            out_upd_reg    <= upd_reg && (op_reg == OP_FEED);
            out_attr_reg   <= attr_reg;
            out_cell_reg   <= cell_reg;
        end
    end

    avtc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cursor_position  = out_cursor_reg;
    assign cursor_updated   = out_upd_reg;
    assign colour_attribute = out_attr_reg;
    assign cell_data        = out_cell_reg;

endmodule

`default_nettype wire

>>> hdl/ansi_vga_text_console.sv
// ansi text console top level: one transaction in, one result transaction out.
// a fed byte passes the feed and done states, a cell read the read address, read data
// and done states; a byte that runs the cursor past the last cell adds a scroll sweep
// over all COLUMNS*ROWS cells, set by the single read and single write port of the
// screen ram (one cell per cycle); a new transaction is taken only in the idle state.
// reset: asynchronous; afterwards a clearing pass fills every screen cell.
`default_nettype none

module ansi_vga_text_console #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_PARAMS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input transaction
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic [10:0] read_address,

    // result transaction
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [10:0] cursor_position,
    output logic             cursor_updated,
    output logic      [7:0]  colour_attribute,
    output logic      [15:0] cell_data
);

    import avtc_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: owns the handshakes, clearing pass and scroll sweep
    // the result register lets the next transaction be taken while a result waits
    avtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: parser, colour state, cursor and screen memory
    avtc_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .data_byte        (data_byte),
        .read_address     (read_address),
        .cursor_position  (cursor_position),
        .cursor_updated   (cursor_updated),
        .colour_attribute (colour_attribute),
        .cell_data        (cell_data)
    );

endmodule

`default_nettype wire

>>> dv/ansi_vga_text_console_tb.sv
// self-checking testbench for the ansi vga text console: a directed table, then random byte streams
// depends on avtc_pkg and ansi_vga_text_console; results are checked against an in-bench console model
module ansi_vga_text_console_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avtc_pkg::*;

    // screen geometry, kept equal to the defaults of the block
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int MAX_PARAMS = 8;
    localparam int CELLS      = COLUMNS * ROWS;

    // run shape
    localparam int RANDOM_ITEMS  = 750;
    localparam int HOLD_AFTER    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;
    // worst case per transaction: sender gap, receiver stall, own cycles and a full scroll
    localparam int SCROLL_CYCLES = CELLS + 1;
    localparam int CYCLE_LIMIT   =
        3 * ((RANDOM_ITEMS + 100) * (SCROLL_CYCLES + 30) + CELLS + HOLD_CYCLES + 1000);

    typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_CSI} csi_phase_t;

    typedef struct packed {
        logic [10:0] cursor;
        logic        updated;
        logic [7:0]  attr;
        logic [15:0] cell_word;
    } console_result_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic [10:0] addr;
    } console_item_t;

    typedef struct packed {
        console_item_t   item;
        logic            typed;
        console_result_t want;
    } stim_row_t;

    // ansi colour index to vga colour index
    localparam logic [2:0] COLOUR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // directed table: expectations typed in only where they are obvious
    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // fresh screen, first cell
        '{'{OP_READ, 8'hFF, 11'd0},    1'b1, '{11'd0, 1'b0, 8'h0F, 16'h0F20}},
        // top of the address field, outside the screen
        '{'{OP_READ, 8'h00, 11'h7FF},  1'b1, '{11'd0, 1'b0, 8'h0F, 16'h0000}},
        // backspace at cell zero does nothing but still rewrites the cursor
        '{'{OP_FEED, CH_BS, 11'h7FF},  1'b1, '{11'd0, 1'b1, 8'h0F, 16'h0000}},
        // high byte dropped
        '{'{OP_FEED, 8'hFF, 11'h000},  1'b1, '{11'd0, 1'b0, 8'h0F, 16'h0000}},
        '{'{OP_FEED, 8'h41, 11'h555},  1'b1, '{11'd1, 1'b1, 8'h0F, 16'h0000}},
        // control bytes land on the screen as characters
        '{'{OP_FEED, 8'h00, 11'h2AA},  1'b0, '0},
        '{'{OP_FEED, 8'h7F, 11'h000},  1'b0, '0},
        // escape followed by a plain byte falls back to idle
        '{'{OP_FEED, CH_ESC, 11'h000}, 1'b0, '0},
        '{'{OP_FEED, 8'h78, 11'h000},  1'b0, '0},
        '{'{OP_FEED, CH_ESC, 11'h000}, 1'b0, '0},
        '{'{OP_FEED, CH_LBRACKET, 11'h000}, 1'b0, '0},
        // a read in the middle of a sequence leaves the parser alone
        '{'{OP_READ, 8'hA5, 11'd1},    1'b0, '0},
        // 999 saturates to 255
        '{'{OP_FEED, 8'h39, 11'h000},  1'b0, '0},
        '{'{OP_FEED, 8'h39, 11'h000},  1'b0, '0},
        '{'{OP_FEED, 8'h39, 11'h000},  1'b0, '0},
        '{'{OP_FEED, CH_SEMI, 11'h000}, 1'b0, '0},
        // empty parameter
        '{'{OP_FEED, CH_SEMI, 11'h000}, 1'b0, '0},
        // bright background 104
        '{'{OP_FEED, 8'h31, 11'h000},  1'b0, '0},
        '{'{OP_FEED, 8'h30, 11'h000},  1'b0, '0},
        '{'{OP_FEED, 8'h34, 11'h000},  1'b0, '0},
        '{'{OP_FEED, CH_SGR, 11'h000}, 1'b0, '0},
        '{'{OP_FEED, CH_LF, 11'h000},  1'b0, '0},
        '{'{OP_FEED, CH_CR, 11'h000},  1'b0, '0},
        '{'{OP_FEED, CH_BS, 11'h000},  1'b0, '0},
        '{'{OP_READ, 8'h5A, 11'd1999}, 1'b0, '0}
    };

    // clock, reset and the block's inputs, all known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        operation    = OP_FEED;
    logic [7:0]  data_byte    = 8'h00;
    logic [10:0] read_address = 11'd0;
    logic        out_ready    = 1'b0;

    wire logic        in_ready;
    wire logic        out_valid;
    wire logic [10:0] cursor_position;
    wire logic        cursor_updated;
    wire logic [7:0]  colour_attribute;
    wire logic [15:0] cell_data;

    // console model state
    csi_phase_t  csi_phase;
    logic [7:0]  csi_params [MAX_PARAMS];
    int          csi_count;
    logic [7:0]  csi_number;
    bit          csi_has_digits;
    logic [7:0]  console_attr;
    int          console_cursor;
    logic [15:0] screen_copy [CELLS];

    // results still owed by the block, oldest first
    console_result_t expected_results [$];
    console_item_t   burst_q [$];

    int items_sent   = 0;
    int results_seen = 0;
    int errors       = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit hold_done    = 1'b0;
    bit quiet_run    = 1'b0;

    ansi_vga_text_console #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .data_byte        (data_byte),
        .read_address     (read_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cursor_position  (cursor_position),
        .cursor_updated   (cursor_updated),
        .colour_attribute (colour_attribute),
        .cell_data        (cell_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // console model
    // ---------------------------------------------------------------

    function automatic void reset_console();
        int i;
        csi_phase      = PH_IDLE;
        csi_count      = 0;
        csi_number     = 8'd0;
        csi_has_digits = 1'b0;
        console_attr   = ATTR_RESET;
        console_cursor = 0;
        for (i = 0; i < MAX_PARAMS; i++)
            csi_params[i] = 8'd0;
        for (i = 0; i < CELLS; i++)
            screen_copy[i] = 16'h0F20;
    endfunction

    // parameters past the last slot are lost
    function automatic void push_csi_param(logic [7:0] v);
        if (csi_count < MAX_PARAMS)
        begin
            csi_params[csi_count] = v;
            csi_count++;
        end
    endfunction

    // every sgr starts from grey on black, bold brightens a normal foreground at the end
    function automatic void run_colour_codes();
        logic [3:0] fg;
        logic [3:0] bg;
        bit         bold;
        logic [7:0] p;
        int         i;
        fg   = 4'd7;
        bg   = 4'd0;
        bold = 1'b0;
        for (i = 0; i < csi_count; i++)
        begin
            p = csi_params[i];
            if (p == 8'd0)
            begin
                fg   = 4'd7;
                bg   = 4'd0;
                bold = 1'b0;
            end
            else if (p == 8'd1)
                bold = 1'b1;
            else if (p >= 8'd30 && p <= 8'd37)
                fg = {1'b0, COLOUR_MAP[3'(p - 8'd30)]};
            else if (p >= 8'd40 && p <= 8'd47)
                bg = {1'b0, COLOUR_MAP[3'(p - 8'd40)]};
            else if (p >= 8'd90 && p <= 8'd97)
                fg = {1'b1, COLOUR_MAP[3'(p - 8'd90)]};
            else if (p >= 8'd100 && p <= 8'd107)
                bg = {1'b1, COLOUR_MAP[3'(p - 8'd100)]};
        end
        if (bold)
            fg[3] = 1'b1;
        console_attr = {bg, fg};
    endfunction

    // move everything up one row, blank the bottom row with the current attribute
    function automatic void scroll_screen();
        int i;
        for (i = 0; i < CELLS - COLUMNS; i++)
            screen_copy[i] = screen_copy[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen_copy[i] = {console_attr, CH_SPACE};
        console_cursor -= COLUMNS;
    endfunction

    // one console byte; returns whether the cursor register is rewritten
    function automatic bit feed_console(logic [7:0] c);
        int v;
        if (csi_phase == PH_ESC)
        begin
            if (c == CH_LBRACKET)
            begin
                csi_phase      = PH_CSI;
                csi_count      = 0;
                csi_number     = 8'd0;
                csi_has_digits = 1'b0;
                return 1'b0;
            end
            csi_phase = PH_IDLE;
        end
        if (csi_phase == PH_CSI)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                v = int'(c - CH_ZERO);
                if (csi_has_digits)
                    v = int'(csi_number) * 10 + v;
                csi_number     = (v > 255) ? 8'd255 : 8'(v);
                csi_has_digits = 1'b1;
                return 1'b0;
            end
            if (c == CH_SEMI)
                push_csi_param(csi_has_digits ? csi_number : 8'd0);
            else
            begin
                // any other byte ends the sequence, only m does anything
                if (csi_has_digits)
                    push_csi_param(csi_number);
                csi_phase = PH_IDLE;
                if (c == CH_SGR)
                    run_colour_codes();
            end
            csi_number     = 8'd0;
            csi_has_digits = 1'b0;
            return 1'b0;
        end
        if (c == CH_ESC)
        begin
            csi_phase = PH_ESC;
            return 1'b0;
        end
        if (c >= 8'h80)
            return 1'b0;
        case (c)
            CH_LF:
                console_cursor = (console_cursor / COLUMNS + 1) * COLUMNS;
            CH_CR:
                console_cursor = (console_cursor / COLUMNS) * COLUMNS;
            CH_BS:
            begin
                if (console_cursor > 0)
                begin
                    console_cursor--;
                    screen_copy[console_cursor] = {console_attr, CH_SPACE};
                end
            end
            default:
            begin
                screen_copy[console_cursor] = {console_attr, c};
                console_cursor++;
            end
        endcase
        if (console_cursor >= CELLS)
            scroll_screen();
        return 1'b1;
    endfunction

    function automatic console_result_t predict_console(console_item_t it);
        console_result_t r;
        r = '0;
        if (it.op == OP_FEED)
            r.updated = feed_console(it.data);
        else if (it.addr < CELLS)
            r.cell_word = screen_copy[it.addr];
        r.cursor = 11'(console_cursor);
        r.attr   = console_attr;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one transaction, optionally after an idle burst, and wait for acceptance
    task automatic send_item(console_item_t it, bit typed, console_result_t want);
        int              gap;
        bit              dropped;
        console_result_t pred;
        if (!quiet_run && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= it.op;
        data_byte    <= it.data;
        read_address <= it.addr;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        // accepted at this edge: advance the model
        dropped = (it.op == OP_FEED && csi_phase == PH_IDLE && it.data >= 8'h80);
        pred    = predict_console(it);
        expected_results.push_back(typed ? want : pred);
        if (!dropped)
            items_sent++;
    endtask

    function automatic void queue_feed(logic [7:0] b);
        console_item_t it;
        it.op   = OP_FEED;
        it.data = b;
        it.addr = 11'($urandom);
        burst_q.push_back(it);
    endfunction

    // mostly on-screen addresses, a few beyond the last cell
    function automatic void queue_read();
        console_item_t it;
        it.op   = OP_READ;
        it.data = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            it.addr = 11'($urandom_range(CELLS, 2047));
        else
            it.addr = 11'($urandom_range(0, CELLS - 1));
        burst_q.push_back(it);
    endfunction

    // -1 means an empty parameter
    function automatic int pick_sgr_code();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 30 + $urandom_range(0, 7);
            3:       return 40 + $urandom_range(0, 7);
            4:       return 90 + $urandom_range(0, 7);
            5:       return 100 + $urandom_range(0, 7);
            6:       return $urandom_range(0, 999);
            default: return -1;
        endcase
    endfunction

    // a final byte other than m: never a digit or a separator
    function automatic logic [7:0] pick_other_final();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_SGR);
        return b;
    endfunction

    // well-formed csi sequence with random content, sometimes overflowing the parameter slots
    function automatic void queue_csi_sequence();
        int    n;
        int    k;
        int    j;
        int    v;
        string digits;
        queue_feed(CH_ESC);
        queue_feed(CH_LBRACKET);
        n = $urandom_range(0, MAX_PARAMS + 3);
        for (k = 0; k < n; k++)
        begin
            if (k > 0)
                queue_feed(CH_SEMI);
            v = pick_sgr_code();
            if (v >= 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    queue_feed(CH_ZERO);
                digits = $sformatf("%0d", v);
                for (j = 0; j < digits.len(); j++)
                    queue_feed(8'(digits[j]));
            end
            if ($urandom_range(0, 19) == 0)
                queue_read();
        end
        if ($urandom_range(0, 9) == 0)
            queue_feed(CH_SEMI);
        if ($urandom_range(0, 7) != 0)
            queue_feed(CH_SGR);
        else
            queue_feed(pick_other_final());
    endfunction

    // printable text with the odd line control and control character
    function automatic void queue_text_run();
        int n;
        int k;
        n = $urandom_range(1, 40);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 19))
                0:       queue_feed(CH_LF);
                1:       queue_feed(CH_CR);
                2:       queue_feed(CH_BS);
                3:       queue_feed(8'($urandom_range(0, 31)));
                default: queue_feed(8'($urandom_range(32, 126)));
            endcase
        end
    endfunction

    // anything at all, including broken escapes and high bytes
    function automatic void queue_noise();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 5))
                0:       queue_read();
                1:
                begin
                    queue_feed(CH_ESC);
                    queue_feed(8'($urandom));
                end
                default: queue_feed(8'($urandom));
            endcase
        end
    endfunction

    function automatic void build_burst();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 32)
            queue_csi_sequence();
        else if (pick < 62)
            queue_text_run();
        else if (pick < 76)
        begin
            for (k = $urandom_range(1, 4); k > 0; k--)
                queue_read();
        end
        else if (pick < 86)
        begin
            for (k = $urandom_range(1, 6); k > 0; k--)
                case ($urandom_range(0, 2))
                    0:       queue_feed(CH_LF);
                    1:       queue_feed(CH_CR);
                    default: queue_feed(CH_BS);
                endcase
        end
        else
            queue_noise();
    endfunction

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_result();
        console_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result transaction", cursor_position, 0);
            return;
        end
        want = expected_results.pop_front();
        if (cursor_position !== want.cursor)
            report_mismatch("cursor_position", cursor_position, want.cursor);
        if (cursor_updated !== want.updated)
            report_mismatch("cursor_updated", cursor_updated, want.updated);
        if (colour_attribute !== want.attr)
            report_mismatch("colour_attribute", colour_attribute, want.attr);
        if (cell_data !== want.cell_word)
            report_mismatch("cell_data", cell_data, want.cell_word);
    endtask

    // result acceptance plus back-pressure: random stall bursts, one long hold-off
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            check_result();
        if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            // long hold-off while the sender keeps offering, fills the block up
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet_run && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int row;
        reset_console();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_item(DIRECTED[row].item, DIRECTED[row].typed, DIRECTED[row].want);

        // random bursts, the tail of the run without any idling
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS * 7 / 8)
                quiet_run = 1'b1;
            build_burst();
            while (burst_q.size() > 0)
                send_item(burst_q.pop_front(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // drain, then keep watching for stray result transactions
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/avtc_pkg.sv
hdl/avtc_ram.sv
hdl/avtc_ctrl.sv
hdl/avtc_datapath.sv
hdl/ansi_vga_text_console.sv
dv/ansi_vga_text_console_tb.sv
